// ===== rtl/brc_pkg.sv =====
`default_nettype none

package brc_pkg;

    localparam int PHASE_W    = 2;
    localparam int ADC_W      = 24;
    localparam int CMD_W      = 8;
    localparam int COEFF_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [PHASE_W-1:0] PH_START = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PRESS = 2'd1;
    localparam logic [PHASE_W-1:0] PH_TEMP  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE  = 2'd3;

    localparam logic [CMD_W-1:0] CMD_NONE       = 8'h00;
    localparam logic [CMD_W-1:0] CMD_CONV_PRESS = 8'h48;
    localparam logic [CMD_W-1:0] CMD_CONV_TEMP  = 8'h58;

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_PRESENT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_COEFF        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_COEFF      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP_COEFF    = 3'd5;

    localparam logic [ADC_W-1:0] PRESSURE_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_out;
        logic [CMD_W-1:0]   command_byte;
        logic               read_request;
        logic [ADC_W-1:0]   pressure;
        logic               pressure_valid;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/brc_if.sv =====
`default_nettype none

interface brc_in_if
    import brc_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] phase_in;
    logic [ADC_W-1:0]   adc_word;

    modport source (output valid, output phase_in, output adc_word, input ready);
    modport sink   (input valid, input phase_in, input adc_word, output ready);
endinterface

interface brc_out_if
    import brc_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] phase_out;
    logic [CMD_W-1:0]   command_byte;
    logic               read_request;
    logic [ADC_W-1:0]   pressure;
    logic               pressure_valid;

    modport source (output valid, output phase_out, output command_byte, output read_request,
                    output pressure, output pressure_valid, input ready);
    modport sink   (input valid, input phase_out, input command_byte, input read_request,
                    input pressure, input pressure_valid, output ready);
endinterface

interface brc_cfg_if
    import brc_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/barometer_readout_compensation.sv =====
// Barometer readout sequencer with first-order pressure compensation. Each input
// transfer carries the measurement phase and a 24-bit ADC word; each one produces
// exactly one result transfer with the next phase, the conversion command, the read
// flag and, in the temperature phase, the compensated pressure clamped to 24 bits.
// Start, pressure and done phases (or any phase with no sensor present) go straight to
// the result register and on to the output register. In the temperature phase one shared
// 25x26 signed multiplier is used four times in sequence (offset term, sensitivity
// term, and the raw pressure product split in two halves), followed by accumulate,
// scale and clamp steps. The input is not ready while an item is in work; a finished
// result sits in an output register so the next item can be taken while it waits.
// Configuration writes are always ready and must only be issued while idle.
`default_nettype none

module barometer_readout_compensation
    import brc_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    brc_in_if.sink      in_ch,
    brc_out_if.source   out_ch,
    brc_cfg_if.sink     cfg_ch
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MOFF  = 10'b0000000010,
        ST_MSENS = 10'b0000000100,
        ST_SENS  = 10'b0000001000,
        ST_MLO   = 10'b0000010000,
        ST_MHI   = 10'b0000100000,
        ST_ACC   = 10'b0001000000,
        ST_SCALE = 10'b0010000000,
        ST_CLAMP = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic               sensor_present_reg;
    logic [COEFF_W-1:0] sens_coeff_reg;
    logic [COEFF_W-1:0] offset_coeff_reg;
    logic [COEFF_W-1:0] sens_temp_coeff_reg;
    logic [COEFF_W-1:0] offset_temp_coeff_reg;
    logic [COEFF_W-1:0] ref_temp_coeff_reg;

    logic [ADC_W-1:0] raw_pressure_reg, raw_pressure_next;

    logic signed [24:0] dt_reg, dt_next;
    logic signed [35:0] off_reg, off_next;
    logic signed [34:0] sens_reg, sens_next;
    logic signed [50:0] prod_reg, prod_next;
    logic signed [60:0] acc_reg, acc_next;
    logic signed [39:0] q_reg, q_next;
    res_t               res_reg, res_next;

    logic               out_valid_reg, out_valid_next;
    res_t               out_data_reg;
    logic               out_load;

    logic signed [24:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [50:0] mul_p;

    logic signed [50:0] off_bias;
    logic signed [50:0] sens_bias;
    logic signed [60:0] acc_bias;
    logic signed [39:0] q_bias;
    logic signed [39:0] p_full;
    logic [ADC_W-1:0]   p_clamped;

    assign mul_p = mul_a * mul_b;

    // truncating divides by powers of two
    assign off_bias  = prod_reg + (prod_reg[50] ? 51'sd127 : 51'sd0);
    assign sens_bias = prod_reg + (prod_reg[50] ? 51'sd255 : 51'sd0);
    assign acc_bias  = acc_reg + (acc_reg[60] ? 61'sd2097151 : 61'sd0);
    assign q_bias    = q_reg + (q_reg[39] ? 40'sd32767 : 40'sd0);
    assign p_full    = q_bias >>> 15;

    always_comb
    begin
        if (p_full[39])
        begin
            p_clamped = '0;
        end
        else if (|p_full[38:24])
        begin
            p_clamped = PRESSURE_MAX;
        end
        else
        begin
            p_clamped = p_full[23:0];
        end
    end

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_load     = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next        = state_reg;
        raw_pressure_next = raw_pressure_reg;
        dt_next           = dt_reg;
        off_next          = off_reg;
        sens_next         = sens_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        q_next            = q_reg;
        res_next          = res_reg;
        mul_a             = '0;
        mul_b             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                    if (sensor_present_reg)
                    begin
                        case (in_ch.phase_in)
                            PH_START:
                            begin
                                res_next.command_byte = CMD_CONV_PRESS;
                                res_next.phase_out    = PH_PRESS;
                            end
                            PH_PRESS:
                            begin
                                raw_pressure_next     = in_ch.adc_word;
                                res_next.read_request = 1'b1;
                                res_next.command_byte = CMD_CONV_TEMP;
                                res_next.phase_out    = PH_TEMP;
                            end
                            PH_TEMP:
                            begin
                                dt_next    = $signed({1'b0, in_ch.adc_word})
                                           - $signed({1'b0, ref_temp_coeff_reg, 8'd0});
                                state_next = ST_MOFF;
                            end
                            default:
                            begin
                                res_next.phase_out = PH_DONE;
                            end
                        endcase
                    end
                end
            end
            ST_MOFF:
            begin
                mul_a      = $signed({9'd0, offset_temp_coeff_reg});
                mul_b      = 26'(dt_reg);
                prod_next  = mul_p;
                state_next = ST_MSENS;
            end
            ST_MSENS:
            begin
                off_next   = 36'(off_bias >>> 7) + $signed({4'd0, offset_coeff_reg, 16'd0});
                mul_a      = $signed({9'd0, sens_temp_coeff_reg});
                mul_b      = 26'(dt_reg);
                prod_next  = mul_p;
                state_next = ST_SENS;
            end
            ST_SENS:
            begin
                sens_next  = 35'(sens_bias >>> 8) + $signed({4'd0, sens_coeff_reg, 15'd0});
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                mul_a      = $signed({1'b0, raw_pressure_reg});
                mul_b      = $signed({8'd0, sens_reg[17:0]});
                prod_next  = mul_p;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                acc_next   = 61'(prod_reg);
                mul_a      = $signed({1'b0, raw_pressure_reg});
                mul_b      = 26'($signed(sens_reg[34:18]));
                prod_next  = mul_p;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next   = acc_reg + (61'(prod_reg) <<< 18);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                q_next     = 40'(acc_bias >>> 21) - 40'(off_reg);
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                res_next.phase_out      = PH_DONE;
                res_next.command_byte   = CMD_NONE;
                res_next.read_request   = 1'b1;
                res_next.pressure       = p_clamped;
                res_next.pressure_valid = 1'b1;
                state_next              = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            out_valid_reg      <= 1'b0;
            raw_pressure_reg   <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            out_valid_reg      <= out_valid_next;
            raw_pressure_reg   <= raw_pressure_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_present_reg    <= 1'b0;
            sens_coeff_reg        <= '0;
            offset_coeff_reg      <= '0;
            sens_temp_coeff_reg   <= '0;
            offset_temp_coeff_reg <= '0;
            ref_temp_coeff_reg    <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_SENSOR_PRESENT:    sensor_present_reg    <= cfg_ch.data[0];
                REG_SENS_COEFF:        sens_coeff_reg        <= cfg_ch.data;
                REG_OFFSET_COEFF:      offset_coeff_reg      <= cfg_ch.data;
                REG_SENS_TEMP_COEFF:   sens_temp_coeff_reg   <= cfg_ch.data;
                REG_OFFSET_TEMP_COEFF: offset_temp_coeff_reg <= cfg_ch.data;
                REG_REF_TEMP_COEFF:    ref_temp_coeff_reg    <= cfg_ch.data;
                default:
                begin
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        dt_reg   <= dt_next;
        off_reg  <= off_next;
        sens_reg <= sens_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.phase_out      = out_data_reg.phase_out;
    assign out_ch.command_byte   = out_data_reg.command_byte;
    assign out_ch.read_request   = out_data_reg.read_request;
    assign out_ch.pressure       = out_data_reg.pressure;
    assign out_ch.pressure_valid = out_data_reg.pressure_valid;

endmodule

`default_nettype wire

// ===== rtl/brc_checker.sv =====
`default_nettype none

module brc_checker
    import brc_pkg::*;
(
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_ready,
    input wire                 out_valid,
    input wire                 out_ready,
    input wire [PHASE_W-1:0]   phase_out,
    input wire [CMD_W-1:0]     command_byte,
    input wire                 read_request,
    input wire [ADC_W-1:0]     pressure,
    input wire                 pressure_valid
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase_out) && $stable(pressure))
        else $error("stalled result changed");

    // busy right after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pressure_valid |-> pressure == '0)
        else $error("pressure set without pressure_valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pressure_valid |->
            phase_out == PH_DONE && read_request && command_byte == CMD_NONE)
        else $error("pressure result with wrong control fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase_out == PH_START |->
            command_byte == CMD_NONE && !read_request && !pressure_valid)
        else $error("idle phase result carries activity");

endmodule

bind barometer_readout_compensation brc_checker u_brc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .phase_out      (out_ch.phase_out),
    .command_byte   (out_ch.command_byte),
    .read_request   (out_ch.read_request),
    .pressure       (out_ch.pressure),
    .pressure_valid (out_ch.pressure_valid)
);

`default_nettype wire

// ===== tb/tb_barometer_readout_compensation.sv =====
`timescale 1ns / 100ps

module tb_barometer_readout_compensation
    import brc_pkg::*;
();

    localparam int HOLD_CYCLES = 200;
    localparam int SETTINGS_RUN = 7;
    localparam int ITEMS_PER_SETTING = 80;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_MOSTLY} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    brc_in_if  in_ch ();
    brc_out_if out_ch ();
    brc_cfg_if cfg_ch ();

    barometer_readout_compensation dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #4 clk = ~clk;

    // predictor state
    logic               sensor_on   = 1'b0;
    logic [COEFF_W-1:0] cal_sens    = '0;
    logic [COEFF_W-1:0] cal_off     = '0;
    logic [COEFF_W-1:0] cal_sens_tc = '0;
    logic [COEFF_W-1:0] cal_off_tc  = '0;
    logic [COEFF_W-1:0] cal_tref    = '0;
    logic [ADC_W-1:0]   raw_press_q = '0;

    res_t reading_q [$];
    res_t want;
    int   err_cnt = 0;

    // sender and receiver pacing
    int          tx_gap_max   = 0;
    int          tx_burst_max = 4;
    int          burst_left   = 0;
    rx_mode_t    rx_mode      = RX_ALWAYS;
    logic [7:0]  hold_req     = '0;
    logic [7:0]  hold_seen    = '0;
    int unsigned hold_left    = 0;
    logic [7:0]  rx_pat       = 8'b1011_0110;

    function automatic res_t compute_reading(input logic [PHASE_W-1:0] ph,
                                             input logic [ADC_W-1:0] w);
        res_t   r;
        longint c1, c2, c3, c4, c5, rp, t;
        longint dt, off, sens, p;
        r = '0;
        if (sensor_on)
        begin
            case (ph)
                PH_START:
                begin
                    r.command_byte = CMD_CONV_PRESS;
                    r.phase_out = PH_PRESS;
                end
                PH_PRESS:
                begin
                    raw_press_q = w;
                    r.read_request = 1'b1;
                    r.command_byte = CMD_CONV_TEMP;
                    r.phase_out = PH_TEMP;
                end
                PH_TEMP:
                begin
                    c1 = longint'(cal_sens);
                    c2 = longint'(cal_off);
                    c3 = longint'(cal_sens_tc);
                    c4 = longint'(cal_off_tc);
                    c5 = longint'(cal_tref);
                    rp = longint'(raw_press_q);
                    t = longint'(w);
                    dt = t - c5 * 256;
                    off = c2 * 65536 + (c4 * dt) / 128;
                    sens = c1 * 32768 + (c3 * dt) / 256;
                    p = ((rp * sens) / 2097152 - off) / 32768;
                    if (p < 0)
                        p = 0;
                    else if (p > longint'(PRESSURE_MAX))
                        p = longint'(PRESSURE_MAX);
                    r.read_request = 1'b1;
                    r.pressure = p[ADC_W-1:0];
                    r.pressure_valid = 1'b1;
                    r.phase_out = PH_DONE;
                end
                default:
                    r.phase_out = PH_DONE;
            endcase
        end
        return r;
    endfunction

    function automatic logic [ADC_W-1:0] pick_word();
        int v;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return PRESSURE_MAX;
            2, 3:
            begin
                v = int'({cal_tref, 8'h00});
                v = v + int'($urandom_range(0, 131071)) - 65536;
                if (v < 0)
                    v = 0;
                else if (v > int'(PRESSURE_MAX))
                    v = int'(PRESSURE_MAX);
                return v[ADC_W-1:0];
            end
            default: return ADC_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [PHASE_W-1:0] ph, input logic [ADC_W-1:0] w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, tx_burst_max);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.phase_in <= ph;
        in_ch.adc_word <= w;
        do @(posedge clk); while (!in_ch.ready);
        reading_q.push_back(compute_reading(ph, w));
    endtask

    task automatic drain_readings();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (reading_q.size() != 0);
    endtask

    task automatic write_config(input logic present,
                                input logic [COEFF_W-1:0] c1, c2, c3, c4, c5);
        logic [CFG_IDX_W-1:0]  idx [8];
        logic [CFG_DATA_W-1:0] val [8];
        drain_readings();
        idx = '{REG_SENSOR_PRESENT, REG_SENS_COEFF, REG_OFFSET_COEFF, REG_SENS_TEMP_COEFF,
                REG_OFFSET_TEMP_COEFF, REG_REF_TEMP_COEFF, REG_SPARE_LO, REG_SPARE_HI};
        val = '{{15'($urandom), present}, c1, c2, c3, c4, c5, 16'($urandom), 16'($urandom)};
        for (int i = 0; i < 8; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data <= val[i];
            do @(posedge clk); while (!cfg_ch.ready);
            case (idx[i])
                REG_SENSOR_PRESENT:    sensor_on = val[i][0];
                REG_SENS_COEFF:        cal_sens = val[i];
                REG_OFFSET_COEFF:      cal_off = val[i];
                REG_SENS_TEMP_COEFF:   cal_sens_tc = val[i];
                REG_OFFSET_TEMP_COEFF: cal_off_tc = val[i];
                REG_REF_TEMP_COEFF:    cal_tref = val[i];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_no_sensor();
        send_item(PH_START, PRESSURE_MAX);
        send_item(PH_PRESS, 24'h5A5A5A);
        send_item(PH_TEMP, 24'hA5A5A5);
        send_item(PH_DONE, PRESSURE_MAX);
        send_item(PH_PRESS, PRESSURE_MAX);
        send_item(PH_TEMP, '0);
    endtask

    task automatic test_directed_compensation();
        // typical calibration and readings
        write_config(1'b1, 16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464);
        send_item(PH_START, '0);
        send_item(PH_PRESS, 24'd9085466);
        send_item(PH_TEMP, 24'd8569150);
        send_item(PH_DONE, PRESSURE_MAX);
        // all coefficients at maximum, word extremes
        write_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(PH_PRESS, PRESSURE_MAX);
        send_item(PH_TEMP, '0);
        send_item(PH_TEMP, PRESSURE_MAX);
        send_item(PH_PRESS, '0);
        send_item(PH_TEMP, PRESSURE_MAX);
        // negative sensitivity drives the result below zero
        write_config(1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_item(PH_PRESS, PRESSURE_MAX);
        send_item(PH_TEMP, '0);
        // large positive result from maximum sensitivity terms and word extremes
        write_config(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_item(PH_PRESS, PRESSURE_MAX);
        send_item(PH_TEMP, PRESSURE_MAX);
        write_config(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(PH_PRESS, 24'hABCDEF);
        send_item(PH_TEMP, 24'h123456);
        // raw pressure must survive a stretch with the sensor absent
        write_config(1'b0, 16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464);
        send_item(PH_PRESS, 24'd9085466);
        send_item(PH_START, '0);
        write_config(1'b1, 16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464);
        send_item(PH_TEMP, 24'd8569150);
        send_item(PH_DONE, '0);
    endtask

    task automatic test_random_readings();
        logic [COEFF_W-1:0] c [1:5];
        int k, n;
        for (int s = 0; s < SETTINGS_RUN; s++)
        begin
            for (k = 1; k <= 5; k++)
            begin
                if (s == 0)
                    c[k] = 16'hFFFF;
                else if (s == 1)
                    c[k] = 16'h0000;
                else
                    case ($urandom_range(0, 5))
                        0: c[k] = 16'h0000;
                        1: c[k] = 16'hFFFF;
                        default: c[k] = COEFF_W'($urandom);
                    endcase
            end
            write_config(s != 5, c[1], c[2], c[3], c[4], c[5]);
            rx_mode <= rx_mode_t'(s % 4);
            tx_gap_max = (s % 3 == 0) ? 0 : $urandom_range(1, 8);
            tx_burst_max = $urandom_range(1, 12);
            n = 0;
            while (n < ITEMS_PER_SETTING)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    send_item(PH_START, ADC_W'($urandom));
                    send_item(PH_PRESS, pick_word());
                    send_item(PH_TEMP, pick_word());
                    n += 3;
                    if ($urandom_range(0, 1) != 0)
                    begin
                        send_item(PH_DONE, ADC_W'($urandom));
                        n++;
                    end
                end
                else
                begin
                    send_item(PHASE_W'($urandom), pick_word());
                    n++;
                end
            end
        end
    endtask

    task automatic test_backpressure();
        write_config(1'b1, 16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464);
        tx_gap_max = 0;
        rx_mode <= RX_ALWAYS;
        hold_req <= hold_req + 1'b1;
        for (int k = 0; k < 16; k++)
            send_item(PHASE_W'(k % 4), pick_word());
        drain_readings();
    endtask

    // result receiver
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS: out_ch.ready <= 1'b1;
                RX_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
                RX_PATTERN:
                begin
                    rx_pat <= {rx_pat[6:0], rx_pat[7]};
                    out_ch.ready <= rx_pat[7];
                end
                default: out_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [ADC_W-1:0] want_v,
                               input logic [ADC_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            err_cnt++;
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (reading_q.size() == 0)
            begin
                err_cnt++;
                $error("result transfer with no reading pending");
            end
            else
            begin
                want = reading_q.pop_front();
                check_field("phase_out", ADC_W'(want.phase_out), ADC_W'(out_ch.phase_out));
                check_field("command_byte", ADC_W'(want.command_byte),
                            ADC_W'(out_ch.command_byte));
                check_field("read_request", ADC_W'(want.read_request),
                            ADC_W'(out_ch.read_request));
                check_field("pressure", want.pressure, out_ch.pressure);
                check_field("pressure_valid", ADC_W'(want.pressure_valid),
                            ADC_W'(out_ch.pressure_valid));
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.phase_in <= PH_START;
        in_ch.adc_word <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_SENSOR_PRESENT;
        cfg_ch.data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_sensor();
        test_directed_compensation();
        test_random_readings();
        test_backpressure();
        drain_readings();
        repeat (16) @(posedge clk);
        if (err_cnt == 0 && reading_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
